// ----- design/shs_pkg.sv -----
package shs_pkg;

  localparam int unsigned SpeedW = 20;
  localparam int unsigned RampW  = 16;
  localparam int unsigned DistW  = 20;
  localparam int unsigned DeltaW = 21;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_POLL   = 2'd1,
    OP_FINISH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OTHER  = 2'd0,
    ST_TARGET = 2'd1,
    ST_STALL  = 2'd2,
    ST_FAULT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_FAST    = 2'd0,
    PH_BACKOFF = 2'd1,
    PH_SLOW    = 2'd2,
    PH_DONE    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MK_NONE = 2'd0,
    MK_CONT = 2'd1,
    MK_REL  = 2'd2
  } move_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAST_SPEED  = 3'd0,
    CFG_FAST_RAMP   = 3'd1,
    CFG_SLOW_SPEED  = 3'd2,
    CFG_SLOW_RAMP   = 3'd3,
    CFG_BACKOFF     = 3'd4,
    CFG_HOME_FWD    = 3'd5,
    CFG_TWO_TOUCH   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SpeedW-1:0] fast_speed;
    logic [RampW-1:0]  fast_ramp_ms;
    logic [SpeedW-1:0] slow_speed;
    logic [RampW-1:0]  slow_ramp_ms;
    logic [DistW-1:0]  backoff_distance;
    logic              home_is_forward;
    logic              two_touch_mode;
  } cfg_t;

  // First field in the highest bits.
  typedef struct packed {
    logic       caller_success;
    logic       motor_moving;
    logic [1:0] motor_status;
    logic [1:0] op;
  } req_t;

  typedef struct packed {
    logic                     homed_ok;
    logic                     finished;
    logic signed [DeltaW-1:0] move_delta;
    logic [RampW-1:0]         move_ramp_ms;
    logic [SpeedW-1:0]        move_speed;
    logic                     move_forward;
    logic [1:0]               move_kind;
    logic                     zero_position;
    logic                     halt_now;
    logic                     enable_stall_stop;
    logic                     clear_fault;
    logic                     clear_stall;
  } result_t;

  localparam int unsigned ReqW = $bits(req_t);
  localparam int unsigned ResW = $bits(result_t);

endpackage

// ----- design/stall_homing_sequencer_unit.sv -----
// Stall homing sequencer for a stepper motor without a home switch.
// Requests enter on the s_axis channel: start, status poll or finish, with
// the motor status, moving flag and caller success flag in tdata. Each
// request produces exactly one result on the m_axis channel carrying the
// motor commands (clear, enable stall stop, halt, zero position, move kind,
// direction, speed, ramp, relative delta) and the finished and homed flags.
// Settings are written through cfg_we_i, cfg_index_i and cfg_wdata_i while
// no request is in flight; they take effect for the next request.
// A request is registered on acceptance, decoded against the phase register
// in the following cycle and lands in the output register, from which its
// result is presented. One request per cycle is sustained while the receiver
// takes every result; the phase update is a single register step per request.
// When the receiver stalls, the output register holds its result and the
// input register takes one more request if it is empty, after which
// s_axis_tready_o drops until the receiver drains. Reset empties both
// registers, puts the phase at done with the success flag cleared, and
// restores the settings to zero except for the forward home direction.
module stall_homing_sequencer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [shs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [shs_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // op[1:0], motor_status[3:2], motor_moving[4], caller_success[5], zero[7:6]
  input  logic [shs_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // clear_stall[0], clear_fault[1], enable_stall_stop[2], halt_now[3],
  // zero_position[4], move_kind[6:5], move_forward[7], move_speed[27:8],
  // move_ramp_ms[43:28], move_delta[64:44], finished[65], homed_ok[66],
  // zero[71:67]
  output logic [shs_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import shs_pkg::*;

  cfg_t    cfg;
  req_t    req;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  assign req = req_t'(s_axis_tdata_i[ReqW-1:0]);

  shs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  shs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  shs_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_ready_o     (res_ready),
    .res_i           (res),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ----- design/shs_cfg.sv -----
module shs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [shs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [shs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output shs_pkg::cfg_t                  cfg_o
);
  import shs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FAST_SPEED: cfg_d.fast_speed       = cfg_wdata_i[SpeedW-1:0];
        CFG_FAST_RAMP:  cfg_d.fast_ramp_ms     = cfg_wdata_i[RampW-1:0];
        CFG_SLOW_SPEED: cfg_d.slow_speed       = cfg_wdata_i[SpeedW-1:0];
        CFG_SLOW_RAMP:  cfg_d.slow_ramp_ms     = cfg_wdata_i[RampW-1:0];
        CFG_BACKOFF:    cfg_d.backoff_distance = cfg_wdata_i[DistW-1:0];
        CFG_HOME_FWD:   cfg_d.home_is_forward  = cfg_wdata_i[0];
        CFG_TWO_TOUCH:  cfg_d.two_touch_mode   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{home_is_forward: 1'b1, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/shs_core.sv -----
module shs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  shs_pkg::cfg_t    cfg_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  shs_pkg::req_t    req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output shs_pkg::result_t res_o
);
  import shs_pkg::*;

  logic    in_valid_q, in_valid_d;
  req_t    in_data_q;
  phase_e  phase_q, phase_d;
  logic    success_q, success_d;
  logic    advance;
  result_t res;
  logic [DeltaW-1:0] dist_ext;

  assign advance     = in_valid_q && res_ready_i;
  assign req_ready_o = !in_valid_q || res_ready_i;
  assign in_valid_d  = req_valid_i ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign dist_ext    = {1'b0, cfg_i.backoff_distance};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      in_data_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DONE;
      success_q <= 1'b0;
    end else if (advance) begin
      phase_q   <= phase_d;
      success_q <= success_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    success_d = success_q;
    res       = '0;
    case (op_e'(in_data_q.op))
      OP_START: begin
        phase_d               = PH_FAST;
        success_d             = 1'b0;
        res.enable_stall_stop = 1'b1;
        res.clear_stall       = 1'b1;
        res.clear_fault       = 1'b1;
        res.move_kind         = MK_CONT;
        res.move_forward      = cfg_i.home_is_forward;
        res.move_speed        = cfg_i.fast_speed;
        res.move_ramp_ms      = cfg_i.fast_ramp_ms;
      end
      OP_POLL: begin
        case (phase_q)
          PH_FAST: begin
            if (status_e'(in_data_q.motor_status) == ST_STALL) begin
              res.clear_stall = 1'b1;
              if (cfg_i.two_touch_mode) begin
                phase_d          = PH_BACKOFF;
                res.move_kind    = MK_REL;
                res.move_speed   = cfg_i.slow_speed;
                res.move_ramp_ms = cfg_i.slow_ramp_ms;
                res.move_delta   = cfg_i.home_is_forward ? -dist_ext : dist_ext;
              end else begin
                phase_d   = PH_DONE;
                success_d = 1'b1;
              end
            end else if (status_e'(in_data_q.motor_status) == ST_FAULT) begin
              phase_d = PH_DONE;
            end
          end
          PH_BACKOFF: begin
            if (status_e'(in_data_q.motor_status) == ST_TARGET) begin
              phase_d          = PH_SLOW;
              res.halt_now     = 1'b1;
              res.move_kind    = MK_CONT;
              res.move_forward = cfg_i.home_is_forward;
              res.move_speed   = cfg_i.slow_speed;
              res.move_ramp_ms = cfg_i.slow_ramp_ms;
            end else if (status_e'(in_data_q.motor_status) == ST_FAULT) begin
              phase_d = PH_DONE;
            end
          end
          PH_SLOW: begin
            if (status_e'(in_data_q.motor_status) == ST_STALL) begin
              res.clear_stall = 1'b1;
              phase_d         = PH_DONE;
              success_d       = 1'b1;
            end else if (status_e'(in_data_q.motor_status) == ST_FAULT) begin
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      OP_FINISH: begin
        res.halt_now      = in_data_q.motor_moving;
        res.clear_stall   = 1'b1;
        res.clear_fault   = 1'b1;
        res.zero_position = in_data_q.caller_success;
      end
      default: ;
    endcase
    res.finished = (phase_d == PH_DONE);
    res.homed_ok = success_d;
  end

  assign res_valid_o = in_valid_q;
  assign res_o       = res;

  a_success_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    success_q |-> phase_q == PH_DONE)
    else $error("success flag set outside the done phase");

  a_start_enters_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_data_q.op == OP_START |=> phase_q == PH_FAST && !success_q)
    else $error("start request did not enter the fast approach");

  a_backoff_only_from_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.move_kind == MK_REL |=> phase_q == PH_BACKOFF && $past(phase_q) == PH_FAST)
    else $error("relative move issued outside the fast-to-back-off step");

endmodule

// ----- design/shs_out_reg.sv -----
module shs_out_reg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  output logic                              res_ready_o,
  input  shs_pkg::result_t                  res_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [shs_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import shs_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign res_ready_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - ResW){1'b0}}, data_q};

  a_load_shows_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_o |=> m_axis_tvalid_o)
    else $error("accepted result not presented on the output");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import shs_pkg::*;

  localparam logic [1:0] OpIgnored   = 2'd3;
  localparam int unsigned IdlePct    = 37;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RunItems   = 200;
  localparam int unsigned RunCount   = 8;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic     is_cfg;
    cfg_idx_e idx;
    logic [CfgDataW-1:0] value;
    req_t     req;
    logic     has_exp;
    result_t  exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [InDataW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  logic steady = 1'b0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  cfg_t    cfg_model;
  phase_e  phase_q;
  logic    success_q;
  result_t due_commands[$];
  row_t    directed[$];

  stall_homing_sequencer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(99) >= IdlePct);
  end

  function automatic result_t with_approach(input result_t res, input logic [SpeedW-1:0] speed,
                                            input logic [RampW-1:0] ramp);
    res.move_kind    = MK_CONT;
    res.move_forward = cfg_model.home_is_forward;
    res.move_speed   = speed;
    res.move_ramp_ms = ramp;
    return res;
  endfunction

  function automatic result_t next_commands(input req_t r);
    result_t res;
    res = '0;
    case (r.op)
      OP_START: begin
        phase_q = PH_FAST;
        success_q = 1'b0;
        res.enable_stall_stop = 1'b1;
        res.clear_stall = 1'b1;
        res.clear_fault = 1'b1;
        res = with_approach(res, cfg_model.fast_speed, cfg_model.fast_ramp_ms);
      end
      OP_POLL: begin
        case (phase_q)
          PH_FAST: begin
            if (r.motor_status == ST_STALL) begin
              res.clear_stall = 1'b1;
              if (cfg_model.two_touch_mode) begin
                res.move_kind    = MK_REL;
                res.move_speed   = cfg_model.slow_speed;
                res.move_ramp_ms = cfg_model.slow_ramp_ms;
                res.move_delta   = cfg_model.home_is_forward ?
                                   -DeltaW'(cfg_model.backoff_distance) :
                                   DeltaW'(cfg_model.backoff_distance);
                phase_q = PH_BACKOFF;
              end else begin
                phase_q = PH_DONE;
                success_q = 1'b1;
              end
            end else if (r.motor_status == ST_FAULT) begin
              phase_q = PH_DONE;
            end
          end
          PH_BACKOFF: begin
            if (r.motor_status == ST_TARGET) begin
              res.halt_now = 1'b1;
              res = with_approach(res, cfg_model.slow_speed, cfg_model.slow_ramp_ms);
              phase_q = PH_SLOW;
            end else if (r.motor_status == ST_FAULT) begin
              phase_q = PH_DONE;
            end
          end
          PH_SLOW: begin
            if (r.motor_status == ST_STALL) begin
              res.clear_stall = 1'b1;
              phase_q = PH_DONE;
              success_q = 1'b1;
            end else if (r.motor_status == ST_FAULT) begin
              phase_q = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
      OP_FINISH: begin
        res.halt_now = r.motor_moving;
        res.clear_stall = 1'b1;
        res.clear_fault = 1'b1;
        res.zero_position = r.caller_success;
      end
      default: begin
      end
    endcase
    res.finished = (phase_q == PH_DONE);
    res.homed_ok = success_q;
    return res;
  endfunction

  function automatic req_t make_req(input logic [1:0] op, input logic [1:0] st,
                                    input logic mv, input logic cs);
    req_t r;
    r.op = op;
    r.motor_status = st;
    r.motor_moving = mv;
    r.caller_success = cs;
    return r;
  endfunction

  function automatic row_t req_row(input logic [1:0] op, input logic [1:0] st,
                                   input logic mv, input logic cs);
    row_t row;
    row = '0;
    row.req = make_req(op, st, mv, cs);
    return row;
  endfunction

  function automatic row_t checked_row(input logic [1:0] op, input logic [1:0] st,
                                       input logic mv, input logic cs, input result_t e);
    row_t row;
    row = req_row(op, st, mv, cs);
    row.has_exp = 1'b1;
    row.exp = e;
    return row;
  endfunction

  function automatic row_t cfg_row(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.value = value;
    return row;
  endfunction

  // Motor commands with zero speed, ramp and delta, as they appear while the settings are at reset.
  function automatic result_t typed(input logic cs, input logic cf, input logic en,
                                    input logic halt, input logic zero,
                                    input logic [1:0] kind, input logic fwd,
                                    input logic fin, input logic ok);
    result_t res;
    res = '0;
    res.clear_stall = cs;
    res.clear_fault = cf;
    res.enable_stall_stop = en;
    res.halt_now = halt;
    res.zero_position = zero;
    res.move_kind = kind;
    res.move_forward = fwd;
    res.finished = fin;
    res.homed_ok = ok;
    return res;
  endfunction

  function automatic req_t pick_request();
    req_t r;
    int unsigned roll;
    r.motor_moving = 1'($urandom_range(1));
    r.caller_success = 1'($urandom_range(1));
    r.motor_status = 2'($urandom_range(3));
    roll = $urandom_range(99);
    if (phase_q == PH_DONE) begin
      if (roll < 65) r.op = OP_START;
      else if (roll < 85) r.op = OP_FINISH;
      else if (roll < 95) r.op = OP_POLL;
      else r.op = OpIgnored;
    end else begin
      if (roll < 86) r.op = OP_POLL;
      else if (roll < 92) r.op = OP_FINISH;
      else if (roll < 97) r.op = OP_START;
      else r.op = OpIgnored;
      roll = $urandom_range(99);
      if (roll < 30) r.motor_status = (phase_q == PH_BACKOFF) ? ST_TARGET : ST_STALL;
      else if (roll < 36) r.motor_status = ST_FAULT;
      else if (roll < 70) r.motor_status = ST_OTHER;
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic check_result(input result_t act, input result_t exp);
    string bad;
    bad = "";
    if (act.clear_stall != exp.clear_stall) bad = {bad, " clear_stall"};
    if (act.clear_fault != exp.clear_fault) bad = {bad, " clear_fault"};
    if (act.enable_stall_stop != exp.enable_stall_stop) bad = {bad, " enable_stall_stop"};
    if (act.halt_now != exp.halt_now) bad = {bad, " halt_now"};
    if (act.zero_position != exp.zero_position) bad = {bad, " zero_position"};
    if (act.move_kind != exp.move_kind) bad = {bad, " move_kind"};
    if (act.move_forward != exp.move_forward) bad = {bad, " move_forward"};
    if (act.move_speed != exp.move_speed) bad = {bad, " move_speed"};
    if (act.move_ramp_ms != exp.move_ramp_ms) bad = {bad, " move_ramp_ms"};
    if (act.move_delta != exp.move_delta) bad = {bad, " move_delta"};
    if (act.finished != exp.finished) bad = {bad, " finished"};
    if (act.homed_ok != exp.homed_ok) bad = {bad, " homed_ok"};
    if (bad != "") begin
      note_failure($sformatf("Mismatch at %0t on%s: expected %h, actual %h",
                             $realtime, bad, exp, act));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (due_commands.size() == 0) begin
        note_failure($sformatf("Unexpected result at %0t: %h", $realtime,
                               m_axis_tdata_o[ResW-1:0]));
      end else begin
        check_result(result_t'(m_axis_tdata_o[ResW-1:0]), due_commands.pop_front());
      end
    end
  end

  task automatic drive_request(input req_t r, input logic has_exp, input result_t typed_exp);
    result_t predicted;
    logic [InDataW-1:0] word;
    word = '0;
    word[ReqW-1:0] = r;
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = next_commands(r);
    due_commands.push_back(has_exp ? typed_exp : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (due_commands.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_setting(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_FAST_SPEED: cfg_model.fast_speed = value[SpeedW-1:0];
      CFG_FAST_RAMP:  cfg_model.fast_ramp_ms = value[RampW-1:0];
      CFG_SLOW_SPEED: cfg_model.slow_speed = value[SpeedW-1:0];
      CFG_SLOW_RAMP:  cfg_model.slow_ramp_ms = value[RampW-1:0];
      CFG_BACKOFF:    cfg_model.backoff_distance = value[DistW-1:0];
      CFG_HOME_FWD:   cfg_model.home_is_forward = value[0];
      CFG_TWO_TOUCH:  cfg_model.two_touch_mode = value[0];
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  task automatic configure_run(input int unsigned run);
    cfg_idx_e idx;
    logic [CfgDataW-1:0] top;
    logic [CfgDataW-1:0] value;
    int unsigned roll;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        CFG_FAST_RAMP, CFG_SLOW_RAMP: top = CfgDataW'({RampW{1'b1}});
        CFG_HOME_FWD, CFG_TWO_TOUCH:  top = CfgDataW'(1);
        default:                      top = {CfgDataW{1'b1}};
      endcase
      roll = $urandom_range(99);
      if (run == 0) value = top;
      else if (run == 1) value = '0;
      else if (roll < 20) value = '0;
      else if (roll < 40) value = top;
      else value = CfgDataW'($urandom) & top;
      if (idx == CFG_TWO_TOUCH && (run < 2 || $urandom_range(99) < 75)) value = CfgDataW'(1);
      write_setting(idx, value);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    req_t stim;
    int unsigned served;
    logic writing;
    cfg_model = '0;
    cfg_model.home_is_forward = 1'b1;
    phase_q = PH_DONE;
    success_q = 1'b0;
    writing = 1'b0;

    directed.push_back(checked_row(OP_POLL, ST_OTHER, 1'b0, 1'b0,
                                   typed(0, 0, 0, 0, 0, MK_NONE, 0, 1, 0)));
    directed.push_back(checked_row(OpIgnored, ST_FAULT, 1'b1, 1'b1,
                                   typed(0, 0, 0, 0, 0, MK_NONE, 0, 1, 0)));
    directed.push_back(checked_row(OP_FINISH, ST_OTHER, 1'b1, 1'b1,
                                   typed(1, 1, 0, 1, 1, MK_NONE, 0, 1, 0)));
    directed.push_back(checked_row(OP_START, ST_OTHER, 1'b0, 1'b0,
                                   typed(1, 1, 1, 0, 0, MK_CONT, 1, 0, 0)));
    directed.push_back(checked_row(OP_POLL, ST_OTHER, 1'b0, 1'b0,
                                   typed(0, 0, 0, 0, 0, MK_NONE, 0, 0, 0)));
    directed.push_back(checked_row(OP_POLL, ST_TARGET, 1'b1, 1'b0,
                                   typed(0, 0, 0, 0, 0, MK_NONE, 0, 0, 0)));
    directed.push_back(checked_row(OP_POLL, ST_STALL, 1'b0, 1'b1,
                                   typed(1, 0, 0, 0, 0, MK_NONE, 0, 1, 1)));
    directed.push_back(checked_row(OP_FINISH, ST_STALL, 1'b0, 1'b0,
                                   typed(1, 1, 0, 0, 0, MK_NONE, 0, 1, 1)));
    directed.push_back(cfg_row(CFG_FAST_SPEED, {CfgDataW{1'b1}}));
    directed.push_back(cfg_row(CFG_FAST_RAMP, CfgDataW'({RampW{1'b1}})));
    directed.push_back(cfg_row(CFG_SLOW_SPEED, {CfgDataW{1'b1}}));
    directed.push_back(cfg_row(CFG_SLOW_RAMP, CfgDataW'({RampW{1'b1}})));
    directed.push_back(cfg_row(CFG_BACKOFF, {CfgDataW{1'b1}}));
    directed.push_back(cfg_row(CFG_HOME_FWD, CfgDataW'(1)));
    directed.push_back(cfg_row(CFG_TWO_TOUCH, CfgDataW'(1)));
    directed.push_back(req_row(OP_START, ST_STALL, 1'b1, 1'b1));
    directed.push_back(req_row(OP_POLL, ST_STALL, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_STALL, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_OTHER, 1'b1, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_TARGET, 1'b0, 1'b1));
    directed.push_back(req_row(OP_POLL, ST_TARGET, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_STALL, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_FAULT, 1'b0, 1'b0));
    directed.push_back(cfg_row(CFG_HOME_FWD, '0));
    directed.push_back(cfg_row(CFG_BACKOFF, CfgDataW'(1)));
    directed.push_back(cfg_row(CFG_FAST_SPEED, CfgDataW'(1)));
    directed.push_back(req_row(OP_START, ST_OTHER, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_FAULT, 1'b0, 1'b0));
    directed.push_back(req_row(OP_START, ST_OTHER, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_STALL, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_FAULT, 1'b0, 1'b0));
    directed.push_back(req_row(OP_START, ST_OTHER, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_STALL, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_TARGET, 1'b0, 1'b0));
    directed.push_back(req_row(OP_POLL, ST_FAULT, 1'b0, 1'b0));
    directed.push_back(req_row(OP_FINISH, ST_OTHER, 1'b1, 1'b0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        if (!writing) wait_idle();
        writing = 1'b1;
        write_setting(directed[i].idx, directed[i].value);
      end else begin
        cfg_we_i <= 1'b0;
        writing = 1'b0;
        drive_request(directed[i].req, directed[i].has_exp, directed[i].exp);
      end
    end

    for (int unsigned run = 0; run < RunCount; run++) begin
      wait_idle();
      steady = (run == 3);
      configure_run(run);
      served = 0;
      while (served < RunItems) begin
        stim = pick_request();
        drive_request(stim, 1'b0, '0);
        if (stim.op != OpIgnored) served++;
      end
    end
    wait_idle();

    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
